### src/psprl_pkg.sv
// ---------------------------------------------------------------------------
// psprl_pkg
// Shared widths, constants, and types for the per-source rate limiter.
// ---------------------------------------------------------------------------
package psprl_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int IDX_W             = 13;
  localparam int ADDR_W            = 32;
  localparam int TIME_W            = 32;
  localparam int SBURST_W          = 14;
  localparam int GBURST_W          = 10;
  localparam int RATE_W            = 10;
  localparam int CFG_IDX_W         = 2;

  localparam logic [ADDR_W-1:0]    LOOPBACK_ADDR  = 32'h0100_007F;
  localparam logic [RATE_W-1:0]    MS_PER_SECOND  = 10'd1000;
  localparam logic [RATE_W-1:0]    RATE_MAX       = 10'd1000;
  localparam logic [3:0]           BURST_FACTOR   = 4'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLB_RATE   = 2'd1;

  typedef struct packed {
    logic                vld;
    logic                found;
    logic [IDX_W-1:0]    hit_idx;
    logic [TIME_W-1:0]   hit_last;
    logic [SBURST_W-1:0] hit_burst;
    logic [IDX_W-1:0]    vic_idx;
    logic [TIME_W-1:0]   vic_time;
  } srch_t;

  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    idx;
    logic [ADDR_W-1:0]   addr;
    logic [TIME_W-1:0]   last;
    logic [SBURST_W-1:0] burst;
  } cwr_t;

  function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
    logic [RATE_W-1:0] v;
    v = r;
    if (r == '0) v = RATE_W'(1);
    else if (r > RATE_MAX) v = RATE_MAX;
    return v;
  endfunction

endpackage

### src/psprl_cell.sv
// ---------------------------------------------------------------------------
// psprl_cell
// One bucket entry; checks the passing search beat and hands it on.
// ---------------------------------------------------------------------------
module psprl_cell #(
  parameter int IDX = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [psprl_pkg::ADDR_W-1:0]    query,
  input  logic [psprl_pkg::IDX_W-1:0]     used,
  input  psprl_pkg::cwr_t                 wr,
  input  psprl_pkg::srch_t                srch_i,
  output psprl_pkg::srch_t                srch_o
);
  import psprl_pkg::*;

  logic [ADDR_W-1:0]   addr_r;
  logic [TIME_W-1:0]   last_r;
  logic [SBURST_W-1:0] burst_r;
  srch_t               srch_r;
  srch_t               srch_nxt;
  logic                live;

  assign live = (IDX_W'(IDX) < used);

  always_comb begin
    srch_nxt = srch_i;
    if (srch_i.vld && live && !srch_i.found) begin
      if (addr_r == query) begin
        srch_nxt.found     = 1'b1;
        srch_nxt.hit_idx   = IDX_W'(IDX);
        srch_nxt.hit_last  = last_r;
        srch_nxt.hit_burst = burst_r;
      end
      if (IDX == 0 || $signed(last_r) < $signed(srch_i.vic_time)) begin
        srch_nxt.vic_idx  = IDX_W'(IDX);
        srch_nxt.vic_time = last_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srch_r.vld <= 1'b0;
    end else begin
      srch_r.vld <= srch_nxt.vld;
    end
    srch_r.found     <= srch_nxt.found;
    srch_r.hit_idx   <= srch_nxt.hit_idx;
    srch_r.hit_last  <= srch_nxt.hit_last;
    srch_r.hit_burst <= srch_nxt.hit_burst;
    srch_r.vic_idx   <= srch_nxt.vic_idx;
    srch_r.vic_time  <= srch_nxt.vic_time;
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == IDX_W'(IDX)) begin
      addr_r  <= wr.addr;
      last_r  <= wr.last;
      burst_r <= wr.burst;
    end
  end

  assign srch_o = srch_r;

endmodule

### src/psprl_div.sv
// ---------------------------------------------------------------------------
// psprl_div
// Restoring divider, 32-bit dividend by 10-bit divisor, one bit per cycle.
// ---------------------------------------------------------------------------
module psprl_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [31:0]                   dividend,
  input  logic [psprl_pkg::RATE_W-1:0]  divisor,
  output logic                          done,
  output logic [31:0]                   quot,
  output logic [psprl_pkg::RATE_W-1:0]  rem
);
  import psprl_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [31:0]       quot_r, quot_nxt;
  logic [RATE_W-1:0] rem_r, rem_nxt;
  logic [RATE_W-1:0] div_r, div_nxt;
  logic [RATE_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    trial    = {rem_r, quot_r[31]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd31;
      quot_nxt = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt  = RATE_W'(trial - {1'b0, div_r});
        quot_nxt = {quot_r[30:0], 1'b1};
      end else begin
        rem_nxt  = trial[RATE_W-1:0];
        quot_nxt = {quot_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

### src/per_source_packet_rate_limiter.sv
// ---------------------------------------------------------------------------
// per_source_packet_rate_limiter
// Per-source leaky-bucket limiter with a global bucket behind it.
// ---------------------------------------------------------------------------
// Input beat: in_source_ip, in_now_ms. Output beat: out_drop, one per input.
// Config beat: cfg_index 0 = per-source rate, 1 = global rate; always ready.
// One request is handled at a time; in_ready is high only while idle.
// Loopback requests go straight from idle to the output state. Others walk
// the chain of TABLE_ENTRIES cells (one cell per cycle), then run up to four
// divisions (two periods, two intervals) in a shared iterative divider;
// fewer run when a time step goes backwards or the source bucket drops.
// Reset clears the fill count and the global bucket and sets the per-source
// rate to 1 and the global rate to RATE_MAX; table entries are written before
// they are ever read, so no clearing pass. A stalled receiver holds out_valid
// and out_drop; no new beat is taken until the result is accepted.
// ---------------------------------------------------------------------------
module per_source_packet_rate_limiter #(
  parameter int TABLE_ENTRIES = psprl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [psprl_pkg::ADDR_W-1:0]      in_source_ip,
  input  logic signed [psprl_pkg::TIME_W-1:0] in_now_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_drop,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [psprl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psprl_pkg::RATE_W-1:0]      cfg_data
);
  import psprl_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SRCH = 9'b000000010,
    S_PDS  = 9'b000000100,
    S_IDS  = 9'b000001000,
    S_SCHK = 9'b000010000,
    S_PDG  = 9'b000100000,
    S_IDG  = 9'b001000000,
    S_GCHK = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [RATE_W-1:0]   rate_s_r, rate_g_r;
  logic [ADDR_W-1:0]   ip_r, ip_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [IDX_W-1:0]    used_r, used_nxt;
  logic [IDX_W-1:0]    slot_r, slot_nxt;
  logic [SBURST_W-1:0] b_r, b_nxt;
  logic [TIME_W-1:0]   l_r, l_nxt;
  logic [TIME_W-1:0]   ival_r, ival_nxt;
  logic [RATE_W-1:0]   period_r, period_nxt;
  logic [GBURST_W-1:0] gb_r, gb_nxt;
  logic [TIME_W-1:0]   gl_r, gl_nxt;
  logic                drop_r, drop_nxt;
  logic                launch_r, launch_nxt;

  logic                div_start;
  logic [31:0]         div_dend;
  logic [RATE_W-1:0]   div_sor;
  logic                div_done;
  logic [31:0]         div_q;
  logic [RATE_W-1:0]   div_rm;

  logic [RATE_W-1:0]   rs, rg;
  logic [SBURST_W-1:0] s_limit;
  cwr_t                wr;
  srch_t               chain [TABLE_ENTRIES+1];
  srch_t               tail;

  assign rs      = clamp_rate(rate_s_r);
  assign rg      = clamp_rate(rate_g_r);
  assign s_limit = SBURST_W'(rs) * SBURST_W'(BURST_FACTOR);

  assign chain[0] = '{vld: launch_r, found: 1'b0, hit_idx: '0, hit_last: '0,
                      hit_burst: '0, vic_idx: '0, vic_time: '0};

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    psprl_cell #(.IDX(g)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .query  (ip_r),
      .used   (used_r),
      .wr     (wr),
      .srch_i (chain[g]),
      .srch_o (chain[g+1])
    );
  end

  assign tail = chain[TABLE_ENTRIES];

  psprl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dend),
    .divisor  (div_sor),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rm)
  );

  always_comb begin
    state_nxt  = state_r;
    ip_nxt     = ip_r;
    now_nxt    = now_r;
    used_nxt   = used_r;
    slot_nxt   = slot_r;
    b_nxt      = b_r;
    l_nxt      = l_r;
    ival_nxt   = ival_r;
    period_nxt = period_r;
    gb_nxt     = gb_r;
    gl_nxt     = gl_r;
    drop_nxt   = drop_r;
    launch_nxt = 1'b0;
    div_start  = 1'b0;
    div_dend   = {22'd0, MS_PER_SECOND};
    div_sor    = rs;
    wr         = '{en: 1'b0, idx: slot_r, addr: ip_r, last: l_r, burst: b_r};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ip_nxt  = in_source_ip;
          now_nxt = in_now_ms;
          if (in_source_ip == LOOPBACK_ADDR) begin
            drop_nxt  = 1'b0;
            state_nxt = S_OUT;
          end else begin
            launch_nxt = 1'b1;
            state_nxt  = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        if (tail.vld) begin
          if (tail.found) begin
            slot_nxt = tail.hit_idx;
            b_nxt    = tail.hit_burst;
            l_nxt    = tail.hit_last;
          end else begin
            if (used_r < IDX_W'(TABLE_ENTRIES)) begin
              slot_nxt = used_r;
              used_nxt = used_r + IDX_W'(1);
            end else begin
              slot_nxt = tail.vic_idx;
            end
            b_nxt = '0;
            l_nxt = '0;
          end
          div_start = 1'b1;
          state_nxt = S_PDS;
        end
      end
      S_PDS: begin
        ival_nxt = now_r - l_r;
        if (div_done) begin
          period_nxt = div_q[RATE_W-1:0];
          if (ival_r[TIME_W-1]) begin
            b_nxt     = '0;
            l_nxt     = now_r;
            state_nxt = S_SCHK;
          end else begin
            div_start = 1'b1;
            div_dend  = ival_r;
            div_sor   = div_q[RATE_W-1:0];
            state_nxt = S_IDS;
          end
        end
      end
      S_IDS: begin
        div_sor  = period_r;
        div_dend = ival_r;
        if (div_done) begin
          if (div_q > {{(32-SBURST_W){1'b0}}, b_r}) begin
            b_nxt = '0;
            l_nxt = now_r;
          end else begin
            b_nxt = b_r - div_q[SBURST_W-1:0];
            l_nxt = now_r - {{(TIME_W-RATE_W){1'b0}}, div_rm};
          end
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        wr.en = 1'b1;
        if (b_r < s_limit) begin
          wr.burst  = b_r + SBURST_W'(1);
          div_start = 1'b1;
          div_sor   = rg;
          ival_nxt  = now_r - gl_r;
          state_nxt = S_PDG;
        end else begin
          drop_nxt  = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_PDG: begin
        div_sor = rg;
        if (div_done) begin
          period_nxt = div_q[RATE_W-1:0];
          if (ival_r[TIME_W-1]) begin
            gb_nxt    = '0;
            gl_nxt    = now_r;
            state_nxt = S_GCHK;
          end else begin
            div_start = 1'b1;
            div_dend  = ival_r;
            div_sor   = div_q[RATE_W-1:0];
            state_nxt = S_IDG;
          end
        end
      end
      S_IDG: begin
        div_sor  = period_r;
        div_dend = ival_r;
        if (div_done) begin
          if (div_q > {{(32-GBURST_W){1'b0}}, gb_r}) begin
            gb_nxt = '0;
            gl_nxt = now_r;
          end else begin
            gb_nxt = gb_r - div_q[GBURST_W-1:0];
            gl_nxt = now_r - {{(TIME_W-RATE_W){1'b0}}, div_rm};
          end
          state_nxt = S_GCHK;
        end
      end
      S_GCHK: begin
        if (gb_r < rg) begin
          gb_nxt   = gb_r + GBURST_W'(1);
          drop_nxt = 1'b0;
        end else begin
          drop_nxt = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      used_r   <= '0;
      gb_r     <= '0;
      gl_r     <= '0;
      rate_s_r <= RATE_W'(1);
      rate_g_r <= RATE_MAX;
      launch_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      gb_r     <= gb_nxt;
      gl_r     <= gl_nxt;
      launch_r <= launch_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SRC_RATE: rate_s_r <= cfg_data;
          CFG_GLB_RATE: rate_g_r <= cfg_data;
          default: ;
        endcase
      end
    end
    ip_r     <= ip_nxt;
    now_r    <= now_nxt;
    slot_r   <= slot_nxt;
    b_r      <= b_nxt;
    l_r      <= l_nxt;
    ival_r   <= ival_nxt;
    period_r <= period_nxt;
    drop_r   <= drop_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_drop  = drop_r;
  assign cfg_ready = 1'b1;

endmodule

### src/psprl_chk.sv
// ---------------------------------------------------------------------------
// psprl_chk
// Port-level checks for the rate limiter, bound to the top level.
// ---------------------------------------------------------------------------
module psprl_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [psprl_pkg::ADDR_W-1:0]      in_source_ip,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_drop
);
  import psprl_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drop))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  a_loopback_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_source_ip == LOOPBACK_ADDR |=> out_valid && !out_drop)
    else $error("loopback beat not passed next cycle");

  a_ready_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("not idle after result beat");

endmodule

bind per_source_packet_rate_limiter psprl_chk u_psprl_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_source_ip (in_source_ip),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_drop     (out_drop)
);

### bench/per_source_packet_rate_limiter_test.sv
// ---------------------------------------------------------------------------
// per_source_packet_rate_limiter_test
// Self-checking bench for the per-source packet rate limiter.
// A directed table covers loopback, address and time extremes, time running
// backwards and per-source drops. Random traffic from a small
// source pool plus fresh sources then forces table eviction. Six rate
// settings are used, with random idling on both sides and one long stall on
// the output side.
// ---------------------------------------------------------------------------
module per_source_packet_rate_limiter_test;
  import psprl_pkg::*;

  localparam int NSLOTS    = TABLE_ENTRIES_DEF;
  localparam int PER_PHASE = 260;
  localparam int WD_LIMIT  = 6000;

  typedef struct {
    logic [ADDR_W-1:0] ip;
    logic [TIME_W-1:0] now;
    bit                known;
    bit                drop;
  } vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ADDR_W-1:0] in_source_ip = '0;
  logic signed [TIME_W-1:0] in_now_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_drop;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RATE_W-1:0] cfg_data = '0;

  per_source_packet_rate_limiter u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // limiter state mirror
  logic [RATE_W-1:0] src_rate_reg = 10'd1, glb_rate_reg = 10'd1000;
  logic [ADDR_W-1:0] tbl_addr[NSLOTS];
  logic [TIME_W-1:0] tbl_last[NSLOTS];
  int unsigned       tbl_burst[NSLOTS];
  int unsigned       tbl_used = 0;
  int unsigned       glb_burst = 0;
  logic [TIME_W-1:0] glb_last = '0;

  bit   drop_q[$];
  int   fails = 0;
  int   send_idle_pct = 0, recv_idle_pct = 0;
  int   stall_token = 0;
  int   idle_cycles = 0;

  function automatic int unsigned eff_rate(logic [RATE_W-1:0] r);
    if (r == 0) return 1;
    if (r > 1000) return 1000;
    return r;
  endfunction

  function automatic bit leak(inout int unsigned b, inout logic [TIME_W-1:0] last,
                              input int unsigned lim, input int unsigned per,
                              input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] ivl;
    ivl = now - last;
    if (ivl[TIME_W-1] || ivl / per > b) begin
      b = 0;
      last = now;
    end else begin
      b = b - ivl / per;
      last = now - (ivl % per);
    end
    if (b < lim) begin
      b = b + 1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit predict_drop(logic [ADDR_W-1:0] ip, logic [TIME_W-1:0] now);
    int unsigned slot, victim, r;
    bit hit, d;
    if (ip == LOOPBACK_ADDR) return 1'b0;
    hit = 1'b0;
    victim = 0;
    slot = 0;
    for (int i = 0; i < tbl_used; i++) begin
      if (!hit && tbl_addr[i] == ip) begin
        hit = 1'b1;
        slot = i;
      end
      if (!hit && $signed(tbl_last[i]) < $signed(tbl_last[victim])) victim = i;
    end
    if (!hit) begin
      if (tbl_used < NSLOTS) begin
        victim = tbl_used;
        tbl_used++;
      end
      slot = victim;
      tbl_addr[slot] = ip;
      tbl_last[slot] = '0;
      tbl_burst[slot] = 0;
    end
    r = eff_rate(src_rate_reg);
    d = leak(tbl_burst[slot], tbl_last[slot], 10 * r, 1000 / r, now);
    tbl_burst[slot] &= 32'h3FFF;
    if (!d) begin
      r = eff_rate(glb_rate_reg);
      d = leak(glb_burst, glb_last, r, 1000 / r, now);
      glb_burst &= 32'h3FF;
    end
    return d;
  endfunction

  // output side: random ready, plus one long hold-off on request
  int seen_token = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (stall_token != seen_token) begin
      seen_token <= stall_token;
      hold_cnt <= 600;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (drop_q.size() == 0) begin
        $error("unexpected result beat drop=%0b", out_drop);
        fails++;
      end else begin
        if (out_drop !== drop_q[0]) begin
          $error("drop: expected %0b actual %0b", drop_q[0], out_drop);
          fails++;
        end
        void'(drop_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send(logic [ADDR_W-1:0] ip, logic [TIME_W-1:0] now, bit known, bit exp);
    bit d;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_source_ip <= ip;
    in_now_ms <= now;
    do @(posedge clk); while (!in_ready);
    d = predict_drop(ip, now);
    if (known && d != exp) begin
      $error("drop: expected %0b actual %0b (table row)", exp, d);
      fails++;
    end
    drop_q.push_back(d);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] val);
    in_valid <= 1'b0;
    while (drop_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SRC_RATE) src_rate_reg = val;
    else if (idx == CFG_GLB_RATE) glb_rate_reg = val;
  endtask

  vec_t dir_tbl[] = '{
    '{LOOPBACK_ADDR, 32'h0, 1, 0},
    '{32'h0A00_0001, 32'h0, 1, 0},
    '{32'h0A00_0001, 32'h0, 0, 0},
    '{32'h0A00_0001, 32'h0, 0, 0},
    '{32'h0A00_0001, 32'h0, 0, 0},
    '{32'h0A00_0001, 32'h0, 0, 0},
    '{32'h0A00_0001, 32'h0, 0, 0},
    '{32'h0A00_0001, 32'h0, 0, 0},
    '{32'h0A00_0001, 32'h0, 0, 0},
    '{32'h0A00_0001, 32'h0, 0, 0},
    '{32'h0A00_0001, 32'h0, 0, 0},
    '{32'h0A00_0001, 32'h0, 1, 1},
    '{32'h0A00_0001, 32'd1500, 0, 0},
    '{LOOPBACK_ADDR, 32'hFFFF_FFFF, 1, 0},
    '{32'h0000_0000, 32'h8000_0000, 1, 0},
    '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 0},
    '{32'hFFFF_FFFF, 32'h7FFF_FFF0, 0, 0},
    '{32'h0A00_0001, 32'hFFFF_FFFF, 0, 0},
    '{32'h0100_007E, 32'h0000_0001, 0, 0},
    '{32'h0100_0080, 32'h0000_0001, 0, 0}
  };

  logic [RATE_W-1:0] src_set[6] = '{10'd1, 10'd0,  10'd1023, 10'd1000, 10'd7, 10'd2};
  logic [RATE_W-1:0] glb_set[6] = '{10'd1000, 10'd5, 10'd1, 10'd3, 10'd0, 10'd1023};

  initial begin
    logic [ADDR_W-1:0] pool[64];
    logic [ADDR_W-1:0] ip;
    logic [TIME_W-1:0] now;
    int n, sel;
    foreach (pool[i]) pool[i] = $urandom;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tbl[i]) send(dir_tbl[i].ip, dir_tbl[i].now, dir_tbl[i].known, dir_tbl[i].drop);

    now = 32'd5000;
    n = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_SRC_RATE, src_set[ph]);
      write_reg(CFG_GLB_RATE, glb_set[ph]);
      write_reg(CFG_IDX_W'(2 + ph % 2), RATE_W'($urandom));
      if (ph == 1) stall_token <= stall_token + 1;
      for (int k = 0; k < PER_PHASE; k++) begin
        send_idle_pct = (n < 520) ? 34 : (n < 1040) ? 57 : 0;
        recv_idle_pct = (n < 520) ? 57 : (n < 1040) ? 34 : 0;
        sel = $urandom_range(99);
        if (sel < 68) ip = pool[$urandom_range(ph < 3 ? 7 : 63)];
        else if (sel < 92) ip = $urandom;
        else ip = LOOPBACK_ADDR;
        sel = $urandom_range(99);
        if (sel < 90) now = now + $urandom_range(0, (ph % 2) ? 400 : 30);
        else if (sel < 96) now = now - $urandom_range(1, 5000);
        else now = $urandom;
        send(ip, now, 0, 0);
        n++;
      end
    end
    in_valid <= 1'b0;
    while (drop_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (fails == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
